// File: hw/rtl/lzf_pkg.sv
// lzf decompressor shared types and constants
package lzf_pkg;
  localparam int HistDepth = 8192;
  localparam int HistAw = $clog2(HistDepth);
  localparam int OutBytes = 8;
  localparam int CountW = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LIT_OVR   = 3'd1,
    ST_NO_LEN    = 3'd2,
    ST_NO_DIST   = 3'd3,
    ST_BAD_REF   = 3'd4,
    ST_SIZE_MISM = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_LEN  = 2'd2,
    PH_DIST = 2'd3
  } phase_t;

  typedef struct packed {
    logic [OutBytes*8-1:0] data;
    logic [CountW-1:0]     count;
    logic                  run_last;
    logic                  block_done;
    logic [2:0]            status;
  } out_item_t;
endpackage

// File: hw/rtl/lzf_in_if.sv
// compressed byte channel
interface lzf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

// File: hw/rtl/lzf_out_if.sv
// decoded data channel
interface lzf_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        run_last;
  logic        block_done;
  logic [2:0]  status;
  modport source (output valid, out_data, out_count, run_last, block_done, status,
                  input ready);
  modport sink (input valid, out_data, out_count, run_last, block_done, status,
                output ready);
endinterface

// File: hw/rtl/lzf_decompressor.sv
// lzf decompressor top level
//  channel  | dir | fields
//  in_req   | in  | in_byte[8], in_last[1]
//  out_req  | out | out_data[64], out_count[4], run_last, block_done, status[3]
//  cfg      | in  | cfg_we, cfg_wdata[32] (expected_size)
// control, extension and literal bytes each pass through an idle and a decode state, a last byte adds a status result
// a back-reference copies one byte at a time through the history memory, a read state then a write state
// per byte, plus an emit state per output word handed off
// after reset a clearing pass zeroes all 8192 history entries, no input taken
// a stalled output holds the sequencer; reset is synchronous and active high
module lzf_decompressor (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_wdata,
  lzf_in_if.sink          in_req,
  lzf_out_if.source       out_req
);
  import lzf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_COPY_RD, S_COPY_WR, S_EMIT, S_STATUS
  } state_t;

  state_t           state;
  logic [HistAw-1:0] clr_addr;
  logic [7:0]       hist [HistDepth];
  logic [7:0]       rd_data;
  logic             hist_we;
  logic [HistAw-1:0] hist_waddr;
  logic [7:0]       hist_wdata;
  logic             hist_re;
  logic [HistAw-1:0] hist_raddr;

  logic [31:0] expected_size;
  logic [31:0] out_total;
  phase_t      phase;
  logic [5:0]  literal_left;
  logic [8:0]  match_length;
  logic [4:0]  distance_high;
  logic [2:0]  error_code;
  logic [7:0]  b;
  logic        last;
  logic [13:0] ref_dist;
  logic [8:0]  copy_left;
  logic [63:0] word;
  logic [3:0]  fill;
  logic        emit_then_copy;
  out_item_t   oreg;
  logic        ovalid;

  // history memory
  always_ff @(posedge clk) begin
    if (hist_we) hist[hist_waddr] <= hist_wdata;
    if (hist_re) rd_data <= hist[hist_raddr];
  end

  logic [31:0] rd_pos;
  assign rd_pos = out_total - {18'd0, ref_dist};
  assign hist_re = (state == S_COPY_RD);
  assign hist_raddr = rd_pos[HistAw-1:0];

  always_comb begin
    hist_we = 1'b0;
    hist_waddr = out_total[HistAw-1:0];
    hist_wdata = b;
    if (state == S_CLEAR) begin
      hist_we = 1'b1;
      hist_waddr = clr_addr;
      hist_wdata = 8'd0;
    end else if (state == S_COPY_WR) begin
      hist_we = 1'b1;
      hist_wdata = rd_data;
    end else if (state == S_DECODE && error_code == ST_OK && phase == PH_LIT) begin
      hist_we = 1'b1;
    end
  end

  assign in_req.ready = (state == S_IDLE);
  assign out_req.valid = ovalid;
  assign out_req.out_data = oreg.data;
  assign out_req.out_count = oreg.count;
  assign out_req.run_last = oreg.run_last;
  assign out_req.block_done = oreg.block_done;
  assign out_req.status = oreg.status;

  logic [32:0] lit_end;
  logic [32:0] ref_end;
  logic [13:0] dist_calc;
  assign lit_end = {1'b0, out_total} + {28'd0, b[4:0]} + 33'd1;
  assign ref_end = {1'b0, out_total} + {24'd0, match_length} + 33'd2;
  assign dist_calc = {1'b0, distance_high, b} + 14'd1;

  logic [2:0] fin_status;
  always_comb begin
    fin_status = error_code;
    if (error_code == ST_OK) begin
      case (phase)
        PH_LIT:  fin_status = ST_LIT_OVR;
        PH_LEN:  fin_status = ST_NO_LEN;
        PH_DIST: fin_status = ST_NO_DIST;
        default: fin_status = (out_total != expected_size) ? ST_SIZE_MISM : ST_OK;
      endcase
    end
  end

  logic out_free;
  assign out_free = !ovalid || out_req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      expected_size <= '0;
      out_total <= '0;
      phase <= PH_CTRL;
      literal_left <= '0;
      match_length <= '0;
      distance_high <= '0;
      error_code <= ST_OK;
      ovalid <= 1'b0;
      emit_then_copy <= 1'b0;
    end else begin
      if (ovalid && out_req.ready) ovalid <= 1'b0;
      if (cfg_we) begin
        expected_size <= cfg_wdata;
        out_total <= '0;
        phase <= PH_CTRL;
        literal_left <= '0;
        match_length <= '0;
        distance_high <= '0;
        error_code <= ST_OK;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == HistAw'(HistDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_req.valid) begin
            b <= in_req.in_byte;
            last <= in_req.in_last;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (out_free) begin
            state <= last ? S_STATUS : S_IDLE;
            if (error_code == ST_OK) begin
              case (phase)
                PH_CTRL: begin
                  if (b < 8'd32) begin
                    if (lit_end > {1'b0, expected_size}) error_code <= ST_LIT_OVR;
                    else begin
                      literal_left <= {1'b0, b[4:0]} + 6'd1;
                      phase <= PH_LIT;
                    end
                  end else begin
                    match_length <= {6'd0, b[7:5]};
                    distance_high <= b[4:0];
                    phase <= (b[7:5] == 3'd7) ? PH_LEN : PH_DIST;
                  end
                end
                PH_LIT: begin
                  out_total <= out_total + 32'd1;
                  oreg <= '{data: {56'd0, b}, count: 4'd1, run_last: !last,
                            block_done: 1'b0, status: 3'd0};
                  ovalid <= 1'b1;
                  literal_left <= literal_left - 6'd1;
                  if (literal_left == 6'd1) phase <= PH_CTRL;
                end
                PH_LEN: begin
                  match_length <= match_length + {1'b0, b};
                  phase <= PH_DIST;
                end
                default: begin
                  phase <= PH_CTRL;
                  if ({18'd0, dist_calc} > out_total || ref_end > {1'b0, expected_size})
                    error_code <= ST_BAD_REF;
                  else begin
                    ref_dist <= dist_calc;
                    copy_left <= match_length + 9'd2;
                    word <= '0;
                    fill <= '0;
                    state <= S_COPY_RD;
                  end
                end
              endcase
            end
          end
        end
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          out_total <= out_total + 32'd1;
          word <= word | ({56'd0, rd_data} << {fill[2:0], 3'b000});
          fill <= fill + 4'd1;
          copy_left <= copy_left - 9'd1;
          if (fill == 4'(OutBytes - 1) || copy_left == 9'd1) begin
            emit_then_copy <= (copy_left != 9'd1);
            state <= S_EMIT;
          end else state <= S_COPY_RD;
        end
        S_EMIT: begin
          if (out_free) begin
            oreg <= '{data: word, count: fill, run_last: !emit_then_copy && !last,
                      block_done: 1'b0, status: 3'd0};
            ovalid <= 1'b1;
            word <= '0;
            fill <= '0;
            state <= emit_then_copy ? S_COPY_RD : (last ? S_STATUS : S_IDLE);
          end
        end
        S_STATUS: begin
          if (out_free) begin
            oreg <= '{data: 64'd0, count: 4'd0, run_last: 1'b1,
                      block_done: 1'b1, status: fin_status};
            ovalid <= 1'b1;
            out_total <= '0;
            phase <= PH_CTRL;
            literal_left <= '0;
            match_length <= '0;
            distance_high <= '0;
            error_code <= ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/lzf_checker.sv
// port level checks for the lzf decompressor
module lzf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_count,
  input logic        run_last,
  input logic        block_done,
  input logic [2:0]  status,
  input logic [63:0] out_data
);
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_done |-> out_count == 4'd0 && run_last && out_data == 64'd0)
    else $error("status result carries data");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= 4'd8) else $error("count too large");
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !block_done |-> status == 3'd0 && out_count != 4'd0)
    else $error("data result malformed");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled request dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");
endmodule

bind lzf_decompressor lzf_checker u_lzf_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_req.valid), .out_ready(out_req.ready),
  .out_count(out_req.out_count), .run_last(out_req.run_last),
  .block_done(out_req.block_done), .status(out_req.status),
  .out_data(out_req.out_data)
);

// File: test/lzf_checker.sv
// lzf decompressor checker: predicts decoded results and compares the output channel
module lzf_scoreboard
  import lzf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  lzf_in_if           in_req,
  lzf_out_if          out_req,
  output int          fail_count,
  output int          pending,
  output int          blocks_done,
  output int          words_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  hist[HistDepth];
  logic [31:0] size_reg;
  logic [31:0] total;
  phase_t      ph;
  int          lit_left;
  logic [8:0]  mlen;
  logic [4:0]  dhigh;
  status_t     err;
  out_item_t   decoded_q[$];

  function automatic void restart();
    total = 0;
    ph = PH_CTRL;
    lit_left = 0;
    mlen = 0;
    dhigh = 0;
    err = ST_OK;
  endfunction

  function automatic void push_item(logic [63:0] d, logic [3:0] c, logic done, status_t s);
    out_item_t it;
    it.data = d;
    it.count = c;
    it.run_last = 1'b0;
    it.block_done = done;
    it.status = s;
    decoded_q = {decoded_q, it};
  endfunction

  function automatic void store(logic [7:0] v);
    hist[total[HistAw-1:0]] = v;
    total = total + 1;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    int n0;
    logic [31:0] ref_dist;
    logic [31:0] len;
    logic [63:0] word;
    int fill;
    logic [7:0] v;
    status_t st;
    n0 = decoded_q.size();
    if (err == ST_OK) begin
      case (ph)
        PH_CTRL: begin
          if (b < 8'd32) begin
            if (longint'(total) + b + 1 > longint'(size_reg)) err = ST_LIT_OVR;
            else begin
              lit_left = b + 1;
              ph = PH_LIT;
            end
          end else begin
            mlen = {6'd0, b[7:5]};
            dhigh = b[4:0];
            ph = (b[7:5] == 3'd7) ? PH_LEN : PH_DIST;
          end
        end
        PH_LIT: begin
          store(b);
          push_item({56'd0, b}, 4'd1, 1'b0, ST_OK);
          lit_left--;
          if (lit_left == 0) ph = PH_CTRL;
        end
        PH_LEN: begin
          mlen = mlen + b;
          ph = PH_DIST;
        end
        PH_DIST: begin
          ref_dist = {19'd0, dhigh, b} + 1;
          len = {23'd0, mlen} + 2;
          if (ref_dist > total || longint'(total) + len > longint'(size_reg)) err = ST_BAD_REF;
          else begin
            word = 0;
            fill = 0;
            for (int i = 0; i < len; i++) begin
              v = hist[(total - ref_dist) % HistDepth];
              store(v);
              word |= 64'(v) << (8 * fill);
              fill++;
              if (fill == OutBytes) begin
                push_item(word, 4'(fill), 1'b0, ST_OK);
                word = 0;
                fill = 0;
              end
            end
            if (fill != 0) push_item(word, 4'(fill), 1'b0, ST_OK);
          end
          ph = PH_CTRL;
        end
      endcase
    end
    if (last) begin
      st = err;
      if (st == ST_OK) begin
        if (ph == PH_LIT) st = ST_LIT_OVR;
        else if (ph == PH_LEN) st = ST_NO_LEN;
        else if (ph == PH_DIST) st = ST_NO_DIST;
        else if (total != size_reg) st = ST_SIZE_MISM;
      end
      push_item(64'd0, 4'd0, 1'b1, st);
      restart();
    end
    if (decoded_q.size() > n0) decoded_q[$].run_last = 1'b1;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    blocks_done = 0;
    words_seen = 0;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      foreach (hist[i]) hist[i] = 8'd0;
      size_reg = 0;
      restart();
      decoded_q.delete();
    end else begin
      if (cfg_we) begin
        size_reg = cfg_wdata;
        restart();
      end
      if (in_req.valid && in_req.ready) decode_byte(in_req.in_byte, in_req.in_last);
      if (out_req.valid && out_req.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: data %h count %0d", out_req.out_data, out_req.out_count);
          fail_count++;
        end else begin
          e = decoded_q.pop_front();
          if (out_req.out_data !== e.data) begin
            $error("out_data: expected %h, got %h", e.data, out_req.out_data);
            fail_count++;
          end
          if (out_req.out_count !== e.count) begin
            $error("out_count: expected %0d, got %0d", e.count, out_req.out_count);
            fail_count++;
          end
          if (out_req.run_last !== e.run_last) begin
            $error("run_last: expected %0b, got %0b", e.run_last, out_req.run_last);
            fail_count++;
          end
          if (out_req.block_done !== e.block_done) begin
            $error("block_done: expected %0b, got %0b", e.block_done, out_req.block_done);
            fail_count++;
          end
          if (out_req.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_req.status);
            fail_count++;
          end
          if (e.block_done) blocks_done++;
          else words_seen++;
        end
      end
    end
    pending <= decoded_q.size();
  end
endmodule

// File: test/testbench.sv
// lzf decompressor testbench top: stimulus, receiver stalls and verdict
module testbench;
  import lzf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          blocks_done;
  int          words_seen;
  int          sent;
  int          got;
  int          quiet;
  bit          no_idle;
  logic [7:0]  strm[$];

  lzf_in_if  in_ch ();
  lzf_out_if out_ch ();

  lzf_decompressor u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_req(in_ch), .out_req(out_ch)
  );

  lzf_scoreboard u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_req(in_ch), .out_req(out_ch), .fail_count(fail_count), .pending(pending),
    .blocks_done(blocks_done), .words_seen(words_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void put_byte(logic [7:0] v);
    strm = {strm, v};
  endfunction

  function automatic void add_lit(int n);
    put_byte(8'(n - 1));
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_copy(int dist_val, int len);
    logic [8:0]  lv;
    logic [12:0] dd;
    lv = 9'(len - 2);
    dd = 13'(dist_val - 1);
    if (lv < 9'd7) put_byte({lv[2:0], dd[12:8]});
    else begin
      put_byte({3'd7, dd[12:8]});
      put_byte(8'(lv - 9'd7));
    end
    put_byte(dd[7:0]);
  endfunction

  function automatic int build_block(int tokens);
    int t;
    int maxd;
    int n;
    t = 0;
    repeat (tokens) begin
      if (t == 0 || $urandom_range(0, 1) == 0) begin
        n = ($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 6);
        add_lit(n);
        t += n;
      end else begin
        maxd = (t < HistDepth) ? t : HistDepth;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 264) : $urandom_range(3, 18);
        add_copy(($urandom_range(0, 3) == 0) ? $urandom_range(1, maxd)
                 : $urandom_range(1, (maxd < 8) ? maxd : 8), n);
        t += n;
      end
    end
    return t;
  endfunction

  task automatic send_byte(logic [7:0] b, logic l);
    int g;
    g = no_idle ? 0 : pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_stream();
    foreach (strm[i]) send_byte(strm[i], i == strm.size() - 1);
    strm.delete();
  endtask

  task automatic set_size(logic [31:0] v);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, one long hold to back up the decoder
  initial begin
    int g;
    bit held;
    held = 0;
    got = 0;
    out_ch.ready <= 1'b0;
    forever begin
      g = pick_gap();
      if (!held && got >= 40) begin
        g = 600;
        held = 1;
      end
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) begin
        @(posedge clk);
        if (out_ch.valid && out_ch.ready) got++;
      end
    end
  end

  // watchdog on cycles with no request moving
  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= 50000) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int total;
    int cut;
    logic [31:0] sz;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 32'd0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'd0;
    in_ch.in_last <= 1'b0;
    sent = 0;
    no_idle = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed blocks
    set_size(32'd5);
    strm = '{8'd31, 8'hAA, 8'h55};
    send_stream();
    set_size(32'd0);
    strm = '{8'hE0};
    send_stream();
    strm = '{8'h20};
    send_stream();
    set_size(32'd272);
    strm = '{8'h07, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h40, 8'hBF,
             8'hE0, 8'hFF, 8'h00};
    send_stream();
    set_size(32'd10);
    strm = '{8'h01, 8'h11, 8'h22, 8'h20, 8'h05};
    send_stream();
    strm = '{8'h01, 8'h33};
    send_stream();
    set_size(32'hFFFF_FFFF);
    strm = '{8'h00, 8'h7E};
    send_stream();
    set_size(32'd3);
    strm = '{8'h00, 8'h11, 8'h20, 8'h00};
    send_stream();
    set_size(32'd100);
    strm = '{8'h00, 8'h11, 8'h3F, 8'hFF};
    send_stream();

    // random blocks
    while (sent < 100) begin
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        total = build_block($urandom_range(1, 4));
        sz = 32'(total);
        if ($urandom_range(0, 9) == 0) sz = $urandom_range(0, 1) ? 32'(total + 1) : 32'(total - 1);
      end else if (mode < 85) begin
        total = build_block($urandom_range(1, 4));
        cut = $urandom_range(1, strm.size());
        while (strm.size() > cut) void'(strm.pop_back());
        sz = 32'(total);
      end else begin
        repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
        sz = $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom();
      end
      if ($urandom_range(0, 4) != 0) set_size(sz);
      no_idle = ($urandom_range(0, 3) == 0);
      send_stream();
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    $display("covered %0d compressed bytes in %0d blocks, %0d data results checked",
             sent, blocks_done, words_seen);
    $display("literal runs, overlapping copies up to 264 bytes, every error status");
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
